// File: rtl/zbm_pkg.sv
`default_nettype none

package zbm_pkg;

    localparam int CODE_W     = 96;
    localparam int HIGH_W     = 32;
    localparam int LOW_W      = 64;
    localparam int TOP_BIT    = CODE_W - 1;
    localparam int BITS_PER_STAGE = 4;
    localparam int NUM_STAGES = CODE_W / BITS_PER_STAGE;
    localparam int NUM_DIMS   = 3;

    // Bit triple {query, zmin, zmax} at the scan position.
    localparam logic [2:0] TRIP_LOWER_MAX = 3'b001;
    localparam logic [2:0] TRIP_ERR_LO    = 3'b010;
    localparam logic [2:0] TRIP_TAKE_MIN  = 3'b011;
    localparam logic [2:0] TRIP_TAKE_BIG  = 3'b100;
    localparam logic [2:0] TRIP_RAISE_MIN = 3'b101;
    localparam logic [2:0] TRIP_ERR_HI    = 3'b110;

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        t_code q;
        t_code zmin;
        t_code zmax;
        t_code big;
        logic  done;
        logic  err;
    } t_work;

    // Bits of the dimension of bit p that sit at or below p.
    function automatic t_code dim_le_mask(int p);
        t_code m;
        m = '0;
        for (int i = p; i >= 0; i -= NUM_DIMS) begin
            m[i] = 1'b1;
        end
        return m;
    endfunction

    // One BIGMIN decision at bit p.
    function automatic t_work bit_step(t_work w, int p);
        t_work r;
        t_code le;
        t_code top;
        t_code rest;
        r    = w;
        le   = dim_le_mask(p);
        top  = t_code'(1) << p;
        rest = le & ~top;
        if (!w.done) begin
            case ({w.q[p], w.zmin[p], w.zmax[p]})
                TRIP_LOWER_MAX: begin
                    r.big  = (w.zmin & ~le) | top;
                    r.zmax = (w.zmax & ~le) | rest;
                end
                TRIP_ERR_LO, TRIP_ERR_HI: begin
                    r.err  = 1'b1;
                    r.done = 1'b1;
                end
                TRIP_TAKE_MIN: begin
                    r.big  = w.zmin;
                    r.done = 1'b1;
                end
                TRIP_TAKE_BIG: begin
                    r.done = 1'b1;
                end
                TRIP_RAISE_MIN: begin
                    r.zmin = (w.zmin & ~le) | top;
                end
                default: begin
                    r = w;
                end
            endcase
        end
        return r;
    endfunction

    // Bits handled by pipeline stage s, highest first.
    function automatic t_work stage_step(t_work w, int s);
        t_work r;
        r = w;
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
            r = bit_step(r, TOP_BIT - BITS_PER_STAGE * s - j);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/zorder_bigmin_3d.sv
`default_nettype none

// BIGMIN for 96-bit 3D Morton codes. Each input word carries a query code and
// the box corners zmin and zmax; the output word returns the smallest code
// inside the box that is larger than the query. Bit p of a code belongs to
// dimension p mod 3. The scan walks from bit 95 to bit 0, four bits per stage,
// through a 24-stage pipeline, and a new word can enter every cycle while the
// output accepts words. Each stage holds its word until the stage after it is
// free, so bubbles close up and a stalled output still lets words enter until
// every stage is full. If a zmin bit of 1 meets a zmax bit of 0 during the
// scan, the result is all ones and tuser (order_error) is 1. When no code in
// the box is larger than the query, the candidate is returned as it stands
// (possibly zero).
module zorder_bigmin_3d (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // query_high, query_low, range_min_high, range_min_low,
    // range_max_high, range_max_low (lowest bits first)
    input  wire logic [287:0] s_axis_tdata,
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // next_high, next_low (lowest bits first)
    output      logic [95:0]  m_axis_tdata,
    // order_error
    output      logic         m_axis_tuser
);

    localparam int NS = zbm_pkg::NUM_STAGES;
    localparam int HW = zbm_pkg::HIGH_W;
    localparam int LW = zbm_pkg::LOW_W;
    localparam int CW = zbm_pkg::CODE_W;

    logic          r_vld [NS];
    zbm_pkg::t_work r_work [NS];
    zbm_pkg::t_work n_work [NS];
    logic          w_rdy [NS+1];
    zbm_pkg::t_work w_in;

    // Unpack the input word; codes are {high, low}.
    always_comb begin
        w_in.q    = {s_axis_tdata[HW-1:0],          s_axis_tdata[HW+LW-1:HW]};
        w_in.zmin = {s_axis_tdata[CW+HW-1:CW],      s_axis_tdata[CW+HW+LW-1:CW+HW]};
        w_in.zmax = {s_axis_tdata[2*CW+HW-1:2*CW],  s_axis_tdata[2*CW+HW+LW-1:2*CW+HW]};
        w_in.big  = '0;
        w_in.done = 1'b0;
        w_in.err  = 1'b0;
    end

    assign w_rdy[NS] = m_axis_tready;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        // A stage takes new data when empty or when its word moves on.
        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];

        if (s == 0) begin : g_first
            always_comb n_work[s] = zbm_pkg::stage_step(w_in, s);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (w_rdy[s]) begin
                    r_vld[s] <= s_axis_tvalid;
                end
            end
        end else begin : g_next
            always_comb n_work[s] = zbm_pkg::stage_step(r_work[s-1], s);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (w_rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end

        // Payload: no reset needed.
        always_ff @(posedge i_clk) begin
            if (w_rdy[s]) begin
                r_work[s] <= n_work[s];
            end
        end
    end

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tuser  = r_work[NS-1].err;

    // Order error forces an all-ones result.
    always_comb begin
        if (r_work[NS-1].err) begin
            m_axis_tdata = '1;
        end else begin
            m_axis_tdata = {r_work[NS-1].big[LW-1:0], r_work[NS-1].big[CW-1:LW]};
        end
    end

endmodule

`default_nettype wire
